>>> rtl/rjl_pkg.sv
// ----------------------------------------------------------------------------
// rjl_pkg: shared constants and types for the RTT, jitter and loss statistics
// Default widths of the statistics datapath and the status bundle of the
// iterative divider.
// ----------------------------------------------------------------------------
package rjl_pkg;

  localparam int RTT_BITS       = 24;
  localparam int COUNT_BITS     = 32;
  localparam int JITTER_SHIFT   = 4;
  localparam int LOSS_FRAC_BITS = 16;
  localparam int SUM_BITS       = 48;

  // Status of the divider as seen by the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

>>> rtl/rjl_div.sv
// ----------------------------------------------------------------------------
// rjl_div: iterative restoring divider for the loss fraction
// Produces floor(num * 2^Q_W / den) for num < den, one quotient bit per cycle
// with a single shared shift, compare and subtract unit.
// ----------------------------------------------------------------------------
module rjl_div #(
  parameter int CNT_W = rjl_pkg::COUNT_BITS,
  parameter int Q_W   = rjl_pkg::LOSS_FRAC_BITS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [CNT_W-1:0]  num,
  input  logic [CNT_W-1:0]  den,
  output logic [Q_W-1:0]    quo,
  output rjl_pkg::div_stat_t stat
);

  localparam int STEP_W = $clog2(Q_W + 1);

  logic [CNT_W-1:0]  rem;
  logic [CNT_W-1:0]  den_r;
  logic [STEP_W-1:0] step;
  logic              busy;
  logic              done;
  logic [CNT_W:0]    rem_sh;
  logic [CNT_W:0]    rem_diff;
  logic              fits;

  // The partial remainder always stays below the divisor, so the shifted
  // value needs only one extra bit.
  assign rem_sh   = {rem, 1'b0};
  assign rem_diff = rem_sh - {1'b0, den_r};
  assign fits     = rem_sh >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + STEP_W'(1);
        if (step == STEP_W'(Q_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= num;
      den_r <= den;
      quo   <= '0;
    end else if (busy) begin
      rem <= fits ? rem_diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
      quo <= {quo[Q_W-2:0], fits};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

>>> rtl/rtt_jitter_loss_stats.sv
// ----------------------------------------------------------------------------
// rtt_jitter_loss_stats: running round-trip time, jitter and loss statistics
// Each accepted item passes through the update and jitter steps and, when
// the loss needs a division, the divider, which retires one quotient bit per
// cycle; with no loss or total loss the division is skipped. The snapshot is
// registered once the output register is free, and a new item is accepted
// only after the snapshot of the last one has been registered.
// Reset: synchronous rst returns all running statistics to their initial values.
// ----------------------------------------------------------------------------
module rtt_jitter_loss_stats #(
  parameter int RTT_BITS       = rjl_pkg::RTT_BITS,
  parameter int COUNT_BITS     = rjl_pkg::COUNT_BITS,
  parameter int JITTER_SHIFT   = rjl_pkg::JITTER_SHIFT,
  parameter int LOSS_FRAC_BITS = rjl_pkg::LOSS_FRAC_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             reply_ok,
  input  logic [RTT_BITS-1:0]              rtt_us,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [COUNT_BITS-1:0]            sent_count,
  output logic [COUNT_BITS-1:0]            received_count,
  output logic [RTT_BITS-1:0]              last_rtt,
  output logic [RTT_BITS-1:0]              min_rtt,
  output logic [RTT_BITS-1:0]              max_rtt,
  output logic [rjl_pkg::SUM_BITS-1:0]     rtt_sum,
  output logic [RTT_BITS+JITTER_SHIFT-1:0] jitter_est,
  output logic [LOSS_FRAC_BITS:0]          loss_fraction,
  output logic                             have_reply
);

  localparam int JIT_BITS  = RTT_BITS + JITTER_SHIFT;
  localparam int LOSS_BITS = LOSS_FRAC_BITS + 1;
  localparam int SUM_BITS  = rjl_pkg::SUM_BITS;

  // The sequencer walks one item through the update, the jitter filter and,
  // when needed, the loss division, then hands the snapshot to the output register.
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_UPD  = 5'b00010,
    S_JIT  = 5'b00100,
    S_DIV  = 5'b01000,
    S_OUT  = 5'b10000
  } seq_state_t;

  seq_state_t state;

  // Running statistics.
  logic [COUNT_BITS-1:0] sent_total;
  logic [COUNT_BITS-1:0] received_total;
  logic [RTT_BITS-1:0]   latest_rtt;
  logic [RTT_BITS-1:0]   lowest_rtt;
  logic [RTT_BITS-1:0]   highest_rtt;
  logic [SUM_BITS-1:0]   rtt_accumulator;
  logic [JIT_BITS-1:0]   jitter_accumulator;

  // Captured item and intermediate values.
  logic                  reply_q;
  logic [RTT_BITS-1:0]   rtt_q;
  logic                  jit_en;
  logic [RTT_BITS-1:0]   rtt_diff;
  logic [LOSS_BITS-1:0]  loss_q;

  logic [SUM_BITS:0]     sum_ext;
  logic [RTT_BITS-1:0]   diff_abs;
  logic [JIT_BITS:0]     jit_ext;
  logic [COUNT_BITS-1:0] lost;
  logic                  loss_none;
  logic                  loss_all;
  logic                  out_load;
  logic                  div_start;
  logic [LOSS_FRAC_BITS-1:0] div_quo;
  rjl_pkg::div_stat_t    div_stat;

  assign in_ready = (state == S_IDLE);

  // The RTT sum saturates when the carry out of the full-width add is set.
  assign sum_ext  = {1'b0, rtt_accumulator} + (SUM_BITS + 1)'(rtt_q);
  assign diff_abs = (rtt_q >= latest_rtt) ? (rtt_q - latest_rtt) : (latest_rtt - rtt_q);

  // RFC 3550 style filter: J - J/2^S + |D|, with an extra bit to detect
  // overflow so that the estimate saturates instead of wrapping.
  assign jit_ext = {1'b0, jitter_accumulator - (jitter_accumulator >> JITTER_SHIFT)}
                   + (JIT_BITS + 1)'(rtt_diff);

  // Loss cases that need no division: nothing lost, or every probe lost.
  assign lost      = sent_total - received_total;
  assign loss_none = (sent_total == '0) || (received_total >= sent_total);
  assign loss_all  = (received_total == '0);
  assign div_start = (state == S_JIT) && !loss_none && !loss_all;
  assign out_load  = (state == S_OUT) && (!out_valid || out_ready);

  rjl_div #(
    .CNT_W (COUNT_BITS),
    .Q_W   (LOSS_FRAC_BITS)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (lost),
    .den   (sent_total),
    .quo   (div_quo),
    .stat  (div_stat)
  );

  // Sequencer and statistics registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_IDLE;
      out_valid          <= 1'b0;
      sent_total         <= '0;
      received_total     <= '0;
      latest_rtt         <= '0;
      lowest_rtt         <= '1;
      highest_rtt        <= '0;
      rtt_accumulator    <= '0;
      jitter_accumulator <= '0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_UPD;
          end
        end
        S_UPD: begin
          if (!(&sent_total)) begin
            sent_total <= sent_total + COUNT_BITS'(1);
          end
          if (reply_q) begin
            if (!(&received_total)) begin
              received_total <= received_total + COUNT_BITS'(1);
            end
            latest_rtt <= rtt_q;
            if (rtt_q < lowest_rtt) begin
              lowest_rtt <= rtt_q;
            end
            if (rtt_q > highest_rtt) begin
              highest_rtt <= rtt_q;
            end
            rtt_accumulator <= sum_ext[SUM_BITS] ? '1 : sum_ext[SUM_BITS-1:0];
          end
          state <= S_JIT;
        end
        S_JIT: begin
          if (jit_en) begin
            jitter_accumulator <= jit_ext[JIT_BITS] ? '1 : jit_ext[JIT_BITS-1:0];
          end
          state <= div_start ? S_DIV : S_OUT;
        end
        S_DIV: begin
          if (div_stat.done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Payload registers: captured item, intermediate values and the snapshot.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          reply_q <= reply_ok;
          rtt_q   <= rtt_us;
        end
      end
      S_UPD: begin
        // Jitter moves from the second counted reply on, that is when a
        // reply was already on record before this one.
        jit_en   <= reply_q && (received_total != '0);
        rtt_diff <= diff_abs;
      end
      S_JIT: begin
        if (loss_none) begin
          loss_q <= '0;
        end else if (loss_all) begin
          loss_q <= LOSS_BITS'(1) << LOSS_FRAC_BITS;
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          loss_q <= {1'b0, div_quo};
        end
      end
      S_OUT: begin
        if (out_load) begin
          sent_count     <= sent_total;
          received_count <= received_total;
          last_rtt       <= latest_rtt;
          min_rtt        <= lowest_rtt;
          max_rtt        <= highest_rtt;
          rtt_sum        <= rtt_accumulator;
          jitter_est     <= jitter_accumulator;
          loss_fraction  <= loss_q;
          have_reply     <= (received_total != '0);
        end
      end
      default: begin
      end
    endcase
  end

  // Replies can never outnumber probes.
  a_recv_le_sent: assert property (@(posedge clk) disable iff (rst)
    received_total <= sent_total)
    else $error("received count exceeds sent count");

  // Once a reply is on record the minimum cannot exceed the maximum.
  a_min_le_max: assert property (@(posedge clk) disable iff (rst)
    (received_total != '0) |-> (lowest_rtt <= highest_rtt))
    else $error("minimum RTT above maximum RTT");

  // The divider only runs while the sequencer waits for it.
  a_div_in_seq: assert property (@(posedge clk) disable iff (rst)
    div_stat.busy |-> (state == S_DIV))
    else $error("divider busy outside the division step");

  // A finished loss fraction never exceeds one.
  a_loss_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT) |-> (loss_q <= (LOSS_BITS'(1) << LOSS_FRAC_BITS)))
    else $error("loss fraction above one");

endmodule
